// ----- rtl/coverage_table_glyph_lookup_macros.svh -----
// Assertion macros shared by the lookup block.
`ifndef COVERAGE_TABLE_GLYPH_LOOKUP_MACROS_SVH
`define COVERAGE_TABLE_GLYPH_LOOKUP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define CTGL_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ctgl: same-cycle check failed");
`define CTGL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ctgl: next-cycle check failed");
`else
`define CTGL_ASSERT_IMPL(label, ante, cons)
`define CTGL_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- rtl/ctgl_pkg.sv -----
package ctgl_pkg;

    localparam int GLYPH_W     = 16;
    localparam int INDEX_W     = 17;
    localparam int FMT_W       = 2;
    localparam int COUNT_W     = 9;
    localparam int ENTRY_IDX_W = 8;
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_IDX_W   = 1;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    localparam logic [FMT_W-1:0] FMT_LIST  = 2'd1;
    localparam logic [FMT_W-1:0] FMT_RANGE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 1'd1;

    typedef struct packed {
        logic [GLYPH_W-1:0] first_glyph;
        logic [GLYPH_W-1:0] last_glyph;
        logic [GLYPH_W-1:0] base_index;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic load;
        logic start;
        logic issue;
        logic capture;
        logic publish;
    } cmd_t;

    typedef struct packed {
        logic done;
    } status_t;

endpackage

// ----- rtl/ctgl_ram.sv -----
module ctgl_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/ctgl_ctrl.sv -----
`include "coverage_table_glyph_lookup_macros.svh"

module ctgl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              req_type,
    output logic              out_valid,
    input  logic              out_stall,
    output ctgl_pkg::cmd_t    cmd,
    input  ctgl_pkg::status_t status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (req_type == ctgl_pkg::REQ_LOOKUP)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
                if (status.done)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    `CTGL_ASSERT_NEXT(a_start_enters_scan, cmd.start, state_reg == ST_SCAN)
    `CTGL_ASSERT_NEXT(a_done_enters_hold, (state_reg == ST_SCAN) && status.done, state_reg == ST_HOLD)
    `CTGL_ASSERT_IMPL(a_result_from_hold, $rose(out_valid_reg), $past(state_reg == ST_HOLD))

endmodule

// ----- rtl/ctgl_dp.sv -----
`include "coverage_table_glyph_lookup_macros.svh"

module ctgl_dp #(
    parameter int MAX_ENTRIES = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ctgl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ctgl_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [ctgl_pkg::ENTRY_IDX_W-1:0]    entry_index,
    input  logic [ctgl_pkg::GLYPH_W-1:0]        start_glyph,
    input  logic [ctgl_pkg::GLYPH_W-1:0]        end_glyph,
    input  logic [ctgl_pkg::GLYPH_W-1:0]        start_coverage_index,
    input  logic [ctgl_pkg::GLYPH_W-1:0]        glyph,
    input  ctgl_pkg::cmd_t                      cmd,
    output ctgl_pkg::status_t                   status,
    output logic                                found,
    output logic [ctgl_pkg::INDEX_W-1:0]        coverage_index
);

    localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW0   = $clog2(MAX_ENTRIES + 1);
    localparam int CNT_W = (CW0 > ctgl_pkg::COUNT_W) ? CW0 : ctgl_pkg::COUNT_W;
    localparam int IW    = (AW > ctgl_pkg::ENTRY_IDX_W) ? AW : ctgl_pkg::ENTRY_IDX_W;

    logic [ctgl_pkg::FMT_W-1:0]   fmt_reg;
    logic [ctgl_pkg::COUNT_W-1:0] count_reg;
    logic [ctgl_pkg::GLYPH_W-1:0] glyph_reg;
    logic [CNT_W-1:0]             rd_cnt_reg;
    logic [CNT_W-1:0]             rd_cnt_next;
    logic [CNT_W-1:0]             chk_addr_reg;
    logic [CNT_W-1:0]             chk_addr_next;
    logic                         chk_valid_reg;
    logic                         chk_valid_next;
    logic                         res_found_reg;
    logic [ctgl_pkg::INDEX_W-1:0] res_index_reg;
    logic                         found_reg;
    logic [ctgl_pkg::INDEX_W-1:0] coverage_index_reg;

    logic [CNT_W-1:0]             n_cnt;
    logic                         none;
    logic                         is_list;
    logic                         is_range;
    logic                         match;
    logic                         last;
    logic                         hit;
    logic [ctgl_pkg::INDEX_W-1:0] hit_index;
    logic [IW-1:0]                load_idx;
    logic                         load_ok;
    logic                         rd_en;
    ctgl_pkg::entry_t             wr_entry;
    ctgl_pkg::entry_t             rd_entry;
    logic [ctgl_pkg::ENTRY_W-1:0] rd_data;

    assign load_idx = IW'(entry_index);
    assign load_ok  = (32'(entry_index) < 32'(MAX_ENTRIES));

    assign wr_entry.first_glyph = start_glyph;
    assign wr_entry.last_glyph  = end_glyph;
    assign wr_entry.base_index  = start_coverage_index;

    ctgl_ram #(
        .WIDTH (ctgl_pkg::ENTRY_W),
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.load && load_ok),
        .waddr (load_idx[AW-1:0]),
        .wdata (wr_entry),
        .re    (rd_en),
        .raddr (rd_cnt_reg[AW-1:0]),
        .rdata (rd_data)
    );

    assign rd_entry = ctgl_pkg::entry_t'(rd_data);

    assign n_cnt    = (32'(count_reg) > 32'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                          : CNT_W'(count_reg);
    assign is_list  = (fmt_reg == ctgl_pkg::FMT_LIST);
    assign is_range = (fmt_reg == ctgl_pkg::FMT_RANGE);
    assign none     = !(is_list || is_range) || (n_cnt == '0);

    always_comb
    begin
        if (is_list)
        begin
            match = (rd_entry.first_glyph == glyph_reg);
        end
        else
        begin
            match = (glyph_reg >= rd_entry.first_glyph) && (glyph_reg <= rd_entry.last_glyph);
        end
    end

    assign last      = (chk_addr_reg == (n_cnt - CNT_W'(1)));
    assign hit       = !none && chk_valid_reg && match;
    assign hit_index = is_list ? ctgl_pkg::INDEX_W'(chk_addr_reg)
                               : ({1'b0, rd_entry.base_index} + {1'b0, glyph_reg}
                                  - {1'b0, rd_entry.first_glyph});

    assign status.done = none || (chk_valid_reg && (match || last));

    always_comb
    begin
        rd_en          = 1'b0;
        rd_cnt_next    = rd_cnt_reg;
        chk_addr_next  = chk_addr_reg;
        chk_valid_next = 1'b0;
        if (cmd.start)
        begin
            rd_cnt_next = '0;
        end
        else if (cmd.issue && (rd_cnt_reg < n_cnt))
        begin
            rd_en          = 1'b1;
            rd_cnt_next    = rd_cnt_reg + CNT_W'(1);
            chk_addr_next  = rd_cnt_reg;
            chk_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg       <= ctgl_pkg::FMT_LIST;
            count_reg     <= '0;
            rd_cnt_reg    <= '0;
            chk_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ctgl_pkg::CFG_FORMAT: fmt_reg   <= cfg_data[ctgl_pkg::FMT_W-1:0];
                    ctgl_pkg::CFG_COUNT:  count_reg <= cfg_data[ctgl_pkg::COUNT_W-1:0];
                    default:              fmt_reg   <= fmt_reg;
                endcase
            end
            rd_cnt_reg    <= rd_cnt_next;
            chk_valid_reg <= chk_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_addr_reg <= chk_addr_next;
        if (cmd.start)
        begin
            glyph_reg <= glyph;
        end
        if (cmd.capture)
        begin
            res_found_reg <= hit;
            res_index_reg <= hit ? hit_index : '0;
        end
        if (cmd.publish)
        begin
            found_reg          <= res_found_reg;
            coverage_index_reg <= res_index_reg;
        end
    end

    assign found          = found_reg;
    assign coverage_index = coverage_index_reg;

    `CTGL_ASSERT_IMPL(a_check_follows_read, $rose(chk_valid_reg), $past(cmd.issue))

endmodule

// ----- rtl/coverage_table_glyph_lookup.sv -----
// Load item: writes one entry of the table RAM, no result.
// Lookup item: entries are read up to the first hit (at most min(entry_count,
// MAX_ENTRIES)); the single RAM read port reads one entry per cycle. One item is in work
// at a time; the next is taken after the result moves to the output register. Reset:
// format 1, entry_count 0, no result; table undefined.
module coverage_table_glyph_lookup #(
    parameter int MAX_ENTRIES = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                req_type,
    input  logic [ctgl_pkg::ENTRY_IDX_W-1:0]    entry_index,
    input  logic [ctgl_pkg::GLYPH_W-1:0]        start_glyph,
    input  logic [ctgl_pkg::GLYPH_W-1:0]        end_glyph,
    input  logic [ctgl_pkg::GLYPH_W-1:0]        start_coverage_index,
    input  logic [ctgl_pkg::GLYPH_W-1:0]        glyph,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                found,
    output logic [ctgl_pkg::INDEX_W-1:0]        coverage_index,
    input  logic                                cfg_we,
    input  logic [ctgl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ctgl_pkg::CFG_DATA_W-1:0]     cfg_data
);

    ctgl_pkg::cmd_t    cmd;
    ctgl_pkg::status_t status;

    ctgl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    ctgl_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .entry_index          (entry_index),
        .start_glyph          (start_glyph),
        .end_glyph            (end_glyph),
        .start_coverage_index (start_coverage_index),
        .glyph                (glyph),
        .cmd                  (cmd),
        .status               (status),
        .found                (found),
        .coverage_index       (coverage_index)
    );

endmodule
